>>> rtl/core/aks_pkg.sv
// shared constants, types and helpers for the array key search block
// no dependencies; used by every file under rtl/core

package aks_pkg;

    localparam int DEPTH      = 128;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IN_W       = 32;
    localparam int POS_W      = 7;
    localparam int ACT_W      = 2;

    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;

    localparam logic METHOD_LINEAR = 1'b0;
    localparam logic METHOD_BINARY = 1'b1;

    typedef logic [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_word             wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_result;

    // sign-extend the 32-bit input word, then cut it to the stored width
    function automatic t_word take_value(input logic [IN_W-1:0] raw);
        logic signed [63:0] ext;
        ext = 64'(signed'(raw));
        return ext[DATA_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/core/aks_store.sv
// element store: one write port, one read port with registered read data
// depends on aks_pkg

module aks_store (
    input  logic                  i_clk,
    input  aks_pkg::t_mem_req     i_req,
    output aks_pkg::t_word        o_rdata
);

    aks_pkg::t_word r_mem [aks_pkg::DEPTH];
    aks_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/aks_seq.sv
// sequencer with one shared compare unit: handles clear, append, linear and
// binary search over the element store; depends on aks_pkg

module aks_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [aks_pkg::ACT_W-1:0]    i_action,
    input  logic [aks_pkg::IN_W-1:0]     i_item_value,
    input  logic                         i_method,
    output aks_pkg::t_mem_req            o_mem_req,
    input  aks_pkg::t_word               i_rdata,
    output aks_pkg::t_result             o_result,
    input  logic                         i_result_ready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LIN    = 3'd1;
    localparam logic [2:0] S_BPROBE = 3'd2;
    localparam logic [2:0] S_BCMP   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam int BW = aks_pkg::CNT_W + 1;  // signed bounds
    localparam int SW = aks_pkg::CNT_W + 2;  // bound sum

    logic [2:0]                   r_state, n_state;
    logic [aks_pkg::CNT_W-1:0]    r_count, n_count;
    aks_pkg::t_word               r_key, n_key;
    logic [aks_pkg::CNT_W-1:0]    r_idx, n_idx;
    logic                         r_pend, n_pend;
    logic [aks_pkg::ADDR_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic signed [BW-1:0]         r_low, n_low;
    logic signed [BW-1:0]         r_high, n_high;
    logic [aks_pkg::ADDR_W-1:0]   r_mid, n_mid;
    logic                         r_hit, n_hit;
    logic [aks_pkg::POS_W-1:0]    r_pos, n_pos;

    logic                         w_accept;
    logic                         w_eq;
    logic                         w_gt;
    logic signed [SW-1:0]         w_sum;
    logic [aks_pkg::ADDR_W-1:0]   w_mid;
    logic signed [BW-1:0]         w_mid_ext;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // shared compare unit
    assign w_eq = (i_rdata == r_key);
    assign w_gt = ($signed(r_key) > $signed(i_rdata));

    assign w_sum     = SW'(r_low) + SW'(r_high);
    assign w_mid     = w_sum[aks_pkg::ADDR_W:1];
    assign w_mid_ext = BW'(r_mid);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_idx     = r_idx;
        n_pend    = r_pend;
        n_cmp_idx = r_cmp_idx;
        n_low     = r_low;
        n_high    = r_high;
        n_mid     = r_mid;
        n_hit     = r_hit;
        n_pos     = r_pos;
        o_mem_req = '0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        aks_pkg::ACT_CLEAR: begin
                            n_count = '0;
                        end
                        aks_pkg::ACT_APPEND: begin
                            if (r_count < aks_pkg::CNT_W'(aks_pkg::DEPTH)) begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_count[aks_pkg::ADDR_W-1:0];
                                o_mem_req.wdata = aks_pkg::take_value(i_item_value);
                                n_count         = r_count + 1'b1;
                            end
                        end
                        aks_pkg::ACT_SEARCH: begin
                            n_key = aks_pkg::take_value(i_item_value);
                            n_hit = 1'b0;
                            n_pos = '0;
                            if (i_method == aks_pkg::METHOD_LINEAR) begin
                                n_idx   = '0;
                                n_pend  = 1'b0;
                                n_state = S_LIN;
                            end else begin
                                n_low   = '0;
                                n_high  = $signed({1'b0, r_count}) - BW'(1);
                                n_state = S_BPROBE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIN: begin
                // compare the word read last cycle while the next read goes out
                if (r_pend && w_eq) begin
                    n_hit   = 1'b1;
                    n_pos   = aks_pkg::POS_W'(r_cmp_idx);
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (r_idx < r_count) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_idx[aks_pkg::ADDR_W-1:0];
                    n_cmp_idx       = r_idx[aks_pkg::ADDR_W-1:0];
                    n_pend          = 1'b1;
                    n_idx           = r_idx + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_BPROBE: begin
                if (r_low <= r_high) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = w_mid;
                    n_mid           = w_mid;
                    n_state         = S_BCMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BCMP: begin
                if (w_eq) begin
                    n_hit   = 1'b1;
                    n_pos   = aks_pkg::POS_W'(r_mid);
                    n_state = S_DONE;
                end else begin
                    if (w_gt) begin
                        n_low = w_mid_ext + BW'(1);
                    end else begin
                        n_high = w_mid_ext - BW'(1);
                    end
                    n_state = S_BPROBE;
                end
            end
            S_DONE: begin
                if (i_result_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result.valid = (r_state == S_DONE);
    assign o_result.hit   = r_hit;
    assign o_result.pos   = r_hit ? r_pos : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_cmp_idx <= n_cmp_idx;
        r_low     <= n_low;
        r_high    <= n_high;
        r_mid     <= n_mid;
        r_pos     <= n_pos;
    end

endmodule

>>> rtl/core/array_key_search.sv
// array key search: store of signed words with clear, append and search
// depends on aks_pkg, aks_store, aks_seq
//
// usage
//   slave stream: s_axis_tdata carries the word to append or the key to
//   search for; s_axis_tuser carries the action (clear, append, search)
//   and the search method (linear first match or binary).
//   master stream: one transfer per search, none for clear, append or an
//   unused action. m_axis_tuser is the found flag, m_axis_tdata the index
//   of the match (zero when not found).
//   clear and append leave the block ready again at once.
//   a linear search reads the n stored words (up to DEPTH) in order until
//   the first match: the single store read port delivers one word per cycle to
//   the compare unit. a binary search reads one word per probe in S_BPROBE
//   and compares it in S_BCMP. the input is not ready while a search runs.
//   reset empties the store (count back to zero) and drops any result in
//   flight; stored words need no clearing.
//   a result waits in the output register while the receiver stalls, and
//   the block keeps taking clear and append transfers meanwhile; a second
//   search holds its result until the register frees up.

module array_key_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] item_value
    input  logic [2:0]  s_axis_tuser,   // [1:0] action, [2] method
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] position, [7] zero
    output logic        m_axis_tuser    // [0] found
);

    aks_pkg::t_mem_req          w_mem_req;
    aks_pkg::t_word             w_rdata;
    aks_pkg::t_result           w_result;
    logic                       w_result_ready;

    logic                       r_out_valid;
    logic                       r_out_found;
    logic [aks_pkg::POS_W-1:0]  r_out_pos;

    assign w_result_ready = !r_out_valid || m_axis_tready;

    aks_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_rdata)
    );

    aks_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_action       (s_axis_tuser[1:0]),
        .i_item_value   (s_axis_tdata),
        .i_method       (s_axis_tuser[2]),
        .o_mem_req      (w_mem_req),
        .i_rdata        (w_rdata),
        .o_result       (w_result),
        .i_result_ready (w_result_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_result_ready) begin
            r_out_valid <= w_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result_ready && w_result.valid) begin
            r_out_found <= w_result.hit;
            r_out_pos   <= w_result.pos;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = {1'b0, r_out_pos};

endmodule

>>> rtl/core/aks_checker.sv
// port-level checks for array_key_search, attached with a bind
// depends on aks_pkg

module aks_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tuser
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a search transfer makes the block busy next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == aks_pkg::ACT_SEARCH)
            |=> !s_axis_tready)
        else $error("ready stayed high after a search transfer");

    // clear, append and unused actions leave the block ready in the next cycle
    a_update_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] != aks_pkg::ACT_SEARCH)
            |=> s_axis_tready)
        else $error("ready dropped after a store update");

    // not found reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
        else $error("nonzero position on a miss");

    // reset drops any pending result
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("result or busy state survived reset");

endmodule

bind array_key_search aks_checker u_aks_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> test/array_key_search_tb.sv
// testbench for array_key_search: drives clear, append and search transfers with random gaps
// and stalls, predicts every search outcome and checks each result in order
// depends on aks_pkg and the array_key_search rtl

module array_key_search_tb;

    localparam logic [aks_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = aks_pkg::DEPTH + 64;

    typedef struct {
        logic                      found;
        logic [aks_pkg::POS_W-1:0] position;
    } t_search_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] item_value
    logic [2:0]  s_axis_tuser;   // [1:0] action, [2] method
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [6:0] position, [7] zero
    logic        m_axis_tuser;   // [0] found

    // predictor state
    aks_pkg::t_word  word_mem [aks_pkg::DEPTH];
    int unsigned     word_count = 0;
    t_search_outcome pending_outcomes [$];
    int              run_words [$];

    int  mismatch_count  = 0;
    int  searches_done   = 0;
    int  hits_seen       = 0;
    int  items_accepted  = 0;
    int  appends_dropped = 0;
    int  quiet_cycles    = 0;
    bit  sender_gaps_on  = 0;
    bit  sink_stalls_on  = 0;
    int  sink_hold       = 0;
    int  sink_roll;

    array_key_search u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sign-extend the key and cut it to the stored width
    function automatic aks_pkg::t_word key_word(input logic [31:0] raw);
        logic signed [63:0] ext;
        ext = {{32{raw[31]}}, raw};
        return ext[aks_pkg::DATA_WIDTH-1:0];
    endfunction

    function automatic t_search_outcome predict_search(input logic [31:0] raw_key,
                                                       input logic meth);
        t_search_outcome res;
        aks_pkg::t_word key;
        int lo;
        int hi;
        int mid;
        key = key_word(raw_key);
        res.found = 1'b0;
        res.position = '0;
        if (meth == aks_pkg::METHOD_LINEAR) begin
            for (int i = 0; i < int'(word_count); i++) begin
                if (word_mem[i] == key) begin
                    res.found = 1'b1;
                    res.position = aks_pkg::POS_W'(i);
                    break;
                end
            end
        end else begin
            lo = 0;
            hi = int'(word_count) - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (word_mem[mid] == key) begin
                    res.found = 1'b1;
                    res.position = aks_pkg::POS_W'(mid);
                    break;
                end
                if ($signed(key) > $signed(word_mem[mid]))
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
        end
        return res;
    endfunction

    // result check first, then the input transfer, so the queue order is fixed
    always @(posedge i_clk) begin
        t_search_outcome want;
        bit moved;
        moved = 0;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            moved = 1;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with nothing expected: found=%0d tdata=%0d",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                searches_done++;
                if (want.found)
                    hits_seen++;
                if (m_axis_tuser !== want.found) begin
                    $display("%0t: found mismatch: expected %0d, actual %0d",
                             $time, want.found, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata !== {1'b0, want.position}) begin
                    $display("%0t: position mismatch: expected %0d, actual %0d",
                             $time, {1'b0, want.position}, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            moved = 1;
            items_accepted++;
            case (s_axis_tuser[1:0])
                aks_pkg::ACT_CLEAR: word_count = 0;
                aks_pkg::ACT_APPEND: begin
                    if (word_count < aks_pkg::DEPTH) begin
                        word_mem[word_count] = key_word(s_axis_tdata);
                        word_count++;
                    end else begin
                        appends_dropped++;
                    end
                end
                aks_pkg::ACT_SEARCH:
                    pending_outcomes.push_back(predict_search(s_axis_tdata, s_axis_tuser[2]));
                default: ;
            endcase
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_outcomes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver backpressure: mostly ready, short stalls, now and then a long one
    always @(negedge i_clk) begin
        if (!sink_stalls_on) begin
            m_axis_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 65) begin
                m_axis_tready <= 1'b1;
                sink_hold <= $urandom_range(0, 4);
            end else if (sink_roll < 93) begin
                m_axis_tready <= 1'b0;
                sink_hold <= $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                sink_hold <= $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (!sender_gaps_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom;
        if (r < 8)
            return 32'($urandom_range(0, 16)) - 32'd8;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // a key that mostly hits the current run, or just misses it
    function automatic logic [31:0] pick_key();
        int r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        if (run_words.size() == 0 || r >= 75)
            return pick_value();
        w = run_words[$urandom_range(0, run_words.size() - 1)];
        if (r < 60)
            return w;
        return (r < 68) ? w + 32'd1 : w - 32'd1;
    endfunction

    // one transfer; tvalid stays high afterwards so back-to-back items need no gap
    task automatic send_item(input logic [aks_pkg::ACT_W-1:0] act, input logic [31:0] value,
                             input logic meth);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {meth, act};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic clear_store();
        send_item(aks_pkg::ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)));
        run_words.delete();
    endtask

    task automatic append_run(input int n, input bit ascending);
        for (int i = 0; i < n; i++)
            run_words.push_back(int'(pick_value()));
        if (ascending)
            run_words.sort();
        foreach (run_words[i])
            send_item(aks_pkg::ACT_APPEND, run_words[i], 1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed();
        send_item(aks_pkg::ACT_CLEAR, 32'h0, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_SEARCH, 32'h0, aks_pkg::METHOD_LINEAR);      // empty store
        send_item(aks_pkg::ACT_SEARCH, 32'h0, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_APPEND, 32'h8000_0000, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_APPEND, 32'hffff_ffff, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_APPEND, 32'h0000_0000, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_APPEND, 32'h0000_0001, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_APPEND, 32'h7fff_ffff, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_SEARCH, 32'h8000_0000, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_SEARCH, 32'h8000_0000, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_SEARCH, 32'h7fff_ffff, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_SEARCH, 32'h7fff_ffff, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_SEARCH, 32'h0000_0000, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_SEARCH, 32'hffff_ffff, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_SEARCH, 32'h0000_0005, aks_pkg::METHOD_LINEAR);  // missing key
        send_item(aks_pkg::ACT_SEARCH, 32'hffff_fffb, aks_pkg::METHOD_BINARY);
        send_item(ACT_UNUSED, 32'hffff_ffff, aks_pkg::METHOD_BINARY);  // ignored, no result
        send_item(aks_pkg::ACT_APPEND, 32'h0000_0001, aks_pkg::METHOD_LINEAR);  // tail duplicate
        send_item(aks_pkg::ACT_SEARCH, 32'h0000_0001, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_SEARCH, 32'h0000_0001, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_CLEAR, 32'hffff_ffff, aks_pkg::METHOD_BINARY);
        send_item(aks_pkg::ACT_SEARCH, 32'hffff_ffff, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_SEARCH, 32'h8000_0000, aks_pkg::METHOD_BINARY);
        wait_drained();
    endtask

    task automatic test_sorted_runs();
        int n;
        repeat (6) begin
            clear_store();
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 16) : $urandom_range(17, 100);
            append_run(n, 1);
            repeat ($urandom_range(4, 10))
                send_item(aks_pkg::ACT_SEARCH, pick_key(),
                          ($urandom_range(0, 3) == 0) ? aks_pkg::METHOD_LINEAR
                                                      : aks_pkg::METHOD_BINARY);
        end
    endtask

    task automatic test_unsorted_runs();
        repeat (5) begin
            clear_store();
            append_run($urandom_range(1, 20), 0);
            repeat ($urandom_range(5, 9))
                send_item(aks_pkg::ACT_SEARCH, pick_key(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic test_full_store();
        clear_store();
        // the minimum word sorts to the front of the run, so it lands in the first slot
        run_words.push_back(32'h8000_0000);
        append_run(aks_pkg::DEPTH - 2, 1);
        // the maximum word fills the last slot
        run_words.push_back(32'h7fff_ffff);
        send_item(aks_pkg::ACT_APPEND, 32'h7fff_ffff, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_SEARCH, 32'h8000_0000, aks_pkg::METHOD_LINEAR);
        repeat (3)
            send_item(aks_pkg::ACT_APPEND, $urandom, 1'($urandom_range(0, 1)));  // dropped
        wait_drained();
        send_item(aks_pkg::ACT_SEARCH, 32'h7fff_ffff, aks_pkg::METHOD_LINEAR);
        send_item(aks_pkg::ACT_SEARCH, 32'h7fff_ffff, aks_pkg::METHOD_BINARY);
        repeat (12)
            send_item(aks_pkg::ACT_SEARCH, pick_key(), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_mixed_noise();
        int r;
        repeat (40) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                send_item(aks_pkg::ACT_CLEAR, $urandom, 1'($urandom_range(0, 1)));
            else if (r < 10)
                send_item(ACT_UNUSED, $urandom, 1'($urandom_range(0, 1)));
            else if (r < 55)
                send_item(aks_pkg::ACT_APPEND, pick_value(), 1'($urandom_range(0, 1)));
            else
                send_item(aks_pkg::ACT_SEARCH, pick_value(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        sender_gaps_on = 1;
        sink_stalls_on = 1;
        test_sorted_runs();
        test_unsorted_runs();
        sender_gaps_on = 0;
        sink_stalls_on = 0;
        test_full_store();
        sender_gaps_on = 1;
        sink_stalls_on = 1;
        test_mixed_noise();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d transfers in: %0d searches checked, %0d hits, %0d appends dropped",
                 items_accepted, searches_done, hits_seen, appends_dropped);
        $display("sorted, unsorted, empty and full stores, both search methods, with backpressure");
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/aks_pkg.sv
rtl/core/aks_store.sv
rtl/core/aks_seq.sv
rtl/core/array_key_search.sv
rtl/core/aks_checker.sv
test/array_key_search_tb.sv
